// ===== rtl/core/sms_pkg.sv =====
// ----------------------------------------------------------------------------
// sms_pkg: shared types and codes of the sparse matrix sum block
// Request codes, job kinds, back-end states and the channel payload structs.
// ----------------------------------------------------------------------------
package sms_pkg;

  // request codes of the input channel
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_EMIT  = 2'd1;
  localparam logic [1:0] REQ_SYM   = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  // configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam int unsigned CFG_W   = 5;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         out_col;
    logic signed [31:0] out_value;
    logic [9:0]         row_start;
    logic               is_symmetric;
    logic               last;
  } out_item_t;

  // work classes handed from the front end to the back end
  typedef enum logic [2:0] {
    K_ADD,
    K_EMIT,
    K_EMPTY,
    K_SYM,
    K_CLR
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  row_index;
    logic [3:0]  col_index;
    logic [31:0] entry_value;
  } job_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_CNT_RD,
    ST_CNT_CHK,
    ST_EM_RD,
    ST_EM_CHK,
    ST_TERM,
    ST_SY_A,
    ST_SY_B,
    ST_SY_C,
    ST_SY_OUT
  } state_t;

endpackage

// ===== rtl/core/sparse_matrix_sum_symmetry.sv =====
// ----------------------------------------------------------------------------
// sparse_matrix_sum_symmetry: sparse matrix sum with symmetry check
// Top level: configuration registers, request front end and job back end.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/in_data and are taken when busy is low. A small
//   queue sits between intake and execution, so a couple of requests can be
//   taken while earlier ones still run.
//   Results leave on out_valid/out_data, one cycle each; the receiver cannot
//   stall them, so it must take every strobe.
//   Work per request (nc, nr = columns and rows in use):
//     add       store read, then write
//     emit row  nonzero entries, terminator last; out-of-range: terminator only
//     symmetry  mirror entries read in turn through the single store read port
//     clear     all DIM*DIM words, one store word per cycle
//   After reset the whole store is swept to zero; busy stays
//   high for that sweep. Configuration writes are taken at any time and take
//   effect at once; write them only while the block is idle.
// ----------------------------------------------------------------------------
module sparse_matrix_sum_symmetry #(
  parameter int unsigned DIM = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sms_pkg::in_item_t   in_data,
  output logic                out_valid,
  output sms_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [4:0]          cfg_data
);
  import sms_pkg::*;

  localparam int unsigned CW = $clog2(DIM + 1);

  logic [CFG_W-1:0] rows_r, cols_r;
  logic [CW-1:0]    nr, nc;
  logic             pop, init_busy, job_valid;
  job_t             job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 5'd16;
      cols_r <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS: rows_r <= cfg_data;
        CFG_COLS: cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // limit to the store size
  assign nr = (int'(rows_r) < DIM) ? CW'(rows_r) : CW'(DIM);
  assign nc = (int'(cols_r) < DIM) ? CW'(cols_r) : CW'(DIM);

  sms_front #(.DIM(DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .nr        (nr),
    .nc        (nc),
    .init_busy (init_busy),
    .pop       (pop),
    .busy      (busy),
    .job_valid (job_valid),
    .job       (job)
  );

  sms_back #(.DIM(DIM)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .nr        (nr),
    .nc        (nc),
    .pop       (pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/sms_ram.sv =====
// ----------------------------------------------------------------------------
// sms_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/sms_front.sv =====
// ----------------------------------------------------------------------------
// sms_front: request intake and classification
// Accepts requests, drops out-of-range adds, and queues jobs for the back end.
// ----------------------------------------------------------------------------
module sms_front #(
  parameter int unsigned DIM = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  sms_pkg::in_item_t          in_data,
  input  logic [$clog2(DIM+1)-1:0]   nr,
  input  logic [$clog2(DIM+1)-1:0]   nc,
  input  logic                       init_busy,
  input  logic                       pop,
  output logic                       busy,
  output logic                       job_valid,
  output sms_pkg::job_t              job
);
  import sms_pkg::*;

  job_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  job_t       cls;
  logic       keep;
  logic       push;

  // classify the incoming request
  always_comb begin
    cls.row_index   = in_data.row_index;
    cls.col_index   = in_data.col_index;
    cls.entry_value = in_data.entry_value;
    cls.kind        = K_ADD;
    keep            = 1'b1;
    case (in_data.req_type)
      REQ_ADD: begin
        keep = (int'(in_data.row_index) < int'(nr)) &&
               (int'(in_data.col_index) < int'(nc));
      end
      REQ_EMIT: begin
        cls.kind = (int'(in_data.row_index) < int'(nr)) ? K_EMIT : K_EMPTY;
      end
      REQ_SYM:   cls.kind = K_SYM;
      REQ_CLEAR: cls.kind = K_CLR;
      default:   keep = 1'b0;
    endcase
  end

  assign busy      = (cnt_r == 2'd2) || init_busy;
  assign push      = start && !busy && keep;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> job_valid) else $error("pop from empty queue");
  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2) else $error("full queue lost entry");

endmodule

// ===== rtl/core/sms_back.sv =====
// ----------------------------------------------------------------------------
// sms_back: job execution sequencer
// Runs adds, row emits, symmetry walks and clears against the sum store.
// ----------------------------------------------------------------------------
module sms_back #(
  parameter int unsigned DIM = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     job_valid,
  input  sms_pkg::job_t            job,
  input  logic [$clog2(DIM+1)-1:0] nr,
  input  logic [$clog2(DIM+1)-1:0] nc,
  output logic                     pop,
  output logic                     init_busy,
  output logic                     out_valid,
  output sms_pkg::out_item_t       out_data
);
  import sms_pkg::*;

  localparam int unsigned CW    = $clog2(DIM + 1);
  localparam int unsigned DEPTH = DIM * DIM;
  localparam int unsigned AW    = $clog2(DEPTH);

  state_t           st_r, st_nxt;
  job_t             job_r, job_nxt;
  logic [CW-1:0]    i_r, i_nxt, j_r, j_nxt, cnt_r, cnt_nxt;
  logic [9:0]       start_r, start_nxt, lpos_r, lpos_nxt;
  logic             ok_r, ok_nxt;
  logic [31:0]      s_r, s_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic             init_r, init_nxt;
  logic             ov_r, ov_nxt;
  out_item_t        od_r, od_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_rdata;
  logic             clr_end;

  assign clr_end = (int'(clr_r) == DEPTH - 1);

  sms_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLR:  if (clr_end) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (job_valid) begin
          case (job.kind)
            K_ADD:   st_nxt = ST_ADD_RD;
            K_EMIT:  st_nxt = ST_CNT_RD;
            K_EMPTY: st_nxt = ST_TERM;
            K_SYM:   st_nxt = ST_SY_A;
            K_CLR:   st_nxt = ST_CLR;
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD:  st_nxt = ST_ADD_WR;
      ST_ADD_WR:  st_nxt = ST_IDLE;
      ST_CNT_RD:  st_nxt = (j_r == nc) ? ST_EM_RD : ST_CNT_CHK;
      ST_CNT_CHK: st_nxt = ST_CNT_RD;
      ST_EM_RD:   st_nxt = (j_r == nc) ? ST_TERM : ST_EM_CHK;
      ST_EM_CHK:  st_nxt = ST_EM_RD;
      ST_TERM:    st_nxt = ST_IDLE;
      ST_SY_A: begin
        if (i_r == nr || !ok_r) begin
          st_nxt = ST_SY_OUT;
        end else if (j_r != nc) begin
          st_nxt = ST_SY_B;
        end
      end
      ST_SY_B: begin
        if (ram_rdata == 32'd0 || j_r >= nr || i_r >= nc) begin
          st_nxt = ST_SY_A;
        end else begin
          st_nxt = ST_SY_C;
        end
      end
      ST_SY_C:   st_nxt = ST_SY_A;
      ST_SY_OUT: st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    job_nxt   = job_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    start_nxt = start_r;
    lpos_nxt  = lpos_r;
    ok_nxt    = ok_r;
    s_nxt     = s_r;
    clr_nxt   = clr_r;
    init_nxt  = init_r;
    ov_nxt    = 1'b0;
    od_nxt    = '0;
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(int'(job_r.row_index) * DIM + int'(job_r.col_index));
    ram_wdata = ram_rdata + job_r.entry_value;
    ram_raddr = ram_waddr;
    case (st_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = 32'd0;
        lpos_nxt  = 10'd0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_end) begin
          init_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        if (job_valid) begin
          pop       = 1'b1;
          job_nxt   = job;
          i_nxt     = '0;
          j_nxt     = '0;
          cnt_nxt   = '0;
          ok_nxt    = 1'b1;
          start_nxt = 10'd0;
          clr_nxt   = '0;
          if (job.kind == K_EMIT && job.row_index == 4'd0) begin
            lpos_nxt = 10'd0;
          end
        end
      end
      ST_ADD_WR: ram_we = 1'b1;
      ST_CNT_RD: begin
        ram_raddr = AW'(int'(job_r.row_index) * DIM + int'(j_r));
        if (j_r == nc) begin
          j_nxt = '0;
          if (cnt_r != '0) begin
            start_nxt = lpos_r + 10'd1;
            lpos_nxt  = lpos_r + 10'(2 * int'(cnt_r) + 1);
          end
        end
      end
      ST_CNT_CHK: begin
        if (ram_rdata != 32'd0) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        j_nxt = j_r + CW'(1);
      end
      ST_EM_RD: ram_raddr = AW'(int'(job_r.row_index) * DIM + int'(j_r));
      ST_EM_CHK: begin
        if (ram_rdata != 32'd0) begin
          ov_nxt           = 1'b1;
          od_nxt.out_col   = 5'(int'(j_r) + 1);
          od_nxt.out_value = ram_rdata;
          od_nxt.row_start = start_r;
        end
        j_nxt = j_r + CW'(1);
      end
      ST_TERM: begin
        ov_nxt           = 1'b1;
        od_nxt.row_start = start_r;
        od_nxt.last      = 1'b1;
      end
      ST_SY_A: begin
        ram_raddr = AW'(int'(i_r) * DIM + int'(j_r));
        if (i_r != nr && ok_r && j_r == nc) begin
          i_nxt = i_r + CW'(1);
          j_nxt = '0;
        end
      end
      ST_SY_B: begin
        ram_raddr = AW'(int'(j_r) * DIM + int'(i_r));
        s_nxt     = ram_rdata;
        if (ram_rdata == 32'd0) begin
          j_nxt = j_r + CW'(1);
        end else if (j_r >= nr || i_r >= nc) begin
          ok_nxt = 1'b0;
        end
      end
      ST_SY_C: begin
        if (ram_rdata != s_r) begin
          ok_nxt = 1'b0;
        end
        j_nxt = j_r + CW'(1);
      end
      ST_SY_OUT: begin
        ov_nxt              = 1'b1;
        od_nxt.is_symmetric = ok_r;
        od_nxt.last         = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLR;
      clr_r  <= '0;
      init_r <= 1'b1;
      lpos_r <= 10'd0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_nxt;
      init_r <= init_nxt;
      lpos_r <= lpos_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    cnt_r   <= cnt_nxt;
    start_r <= start_nxt;
    ok_r    <= ok_nxt;
    s_r     <= s_nxt;
    od_r    <= od_nxt;
  end

  assign init_busy = init_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> st_r == ST_IDLE) else $error("job taken while busy");
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (st_r == ST_CLR || st_r == ST_ADD_WR)) else $error("stray store write");
  a_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !od_r.last) |-> (od_r.out_col != 5'd0 && od_r.out_value != 32'sd0))
    else $error("bad row transaction");
  a_no_out_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> !ov_r) else $error("result during initial clear");

endmodule
